// ----- rtl/core/line_editor_with_history_unit_macros.svh -----
// Assertion macros shared by the line editor RTL.
`ifndef LINE_EDITOR_WITH_HISTORY_UNIT_MACROS_SVH
`define LINE_EDITOR_WITH_HISTORY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LEDIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LEDIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// ----- rtl/core/ledit_pkg.sv -----
// Types and constants shared by the line editor modules.
`timescale 1ns / 1ps

package ledit_pkg;

    typedef enum logic [2:0] {
        OP_KEY   = 3'd0,
        OP_LEFT  = 3'd1,
        OP_RIGHT = 3'd2,
        OP_HOME  = 3'd3,
        OP_END   = 3'd4,
        OP_OLDER = 3'd5,
        OP_NEWER = 3'd6,
        OP_READ  = 3'd7
    } op_t;

    localparam logic [7:0] KEY_CTRL_A    = 8'd1;
    localparam logic [7:0] KEY_CTRL_C    = 8'd3;
    localparam logic [7:0] KEY_CTRL_D    = 8'd4;
    localparam logic [7:0] KEY_CTRL_E    = 8'd5;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_LF        = 8'd10;
    localparam logic [7:0] KEY_CTRL_K    = 8'd11;
    localparam logic [7:0] KEY_CR        = 8'd13;
    localparam logic [7:0] KEY_CTRL_U    = 8'd21;
    localparam logic [7:0] KEY_CTRL_W    = 8'd23;
    localparam logic [7:0] KEY_SPACE     = 8'd32;
    localparam logic [7:0] KEY_PRINT_LO  = 8'd32;
    localparam logic [7:0] KEY_PRINT_HI  = 8'd126;
    localparam logic [7:0] KEY_DELETE    = 8'd127;

    typedef enum logic [2:0] {
        KIND_SIMPLE,
        KIND_INSERT,
        KIND_BKSP,
        KIND_DEL,
        KIND_WORD,
        KIND_ENTER,
        KIND_LOAD,
        KIND_READ
    } kind_t;

    typedef enum logic [4:0] {
        DC_NONE,
        DC_CAPTURE,
        DC_SIMPLE,
        DC_INS_START,
        DC_INS_STEP,
        DC_INS_PUT,
        DC_BS_START,
        DC_DEL_START,
        DC_REM_STEP,
        DC_REM_END,
        DC_WORD_START,
        DC_WORD_STEP,
        DC_WORD_END,
        DC_ENT_START,
        DC_ENT_STEP,
        DC_ENT_END,
        DC_PSH_STEP,
        DC_PSH_END,
        DC_LD_START,
        DC_LD_STEP,
        DC_LD_END,
        DC_OUT_LOAD
    } dp_cmd_t;

    typedef enum logic [2:0] {
        MODE_INS,
        MODE_REM,
        MODE_WORD,
        MODE_ENTER,
        MODE_PUSH,
        MODE_LOAD
    } mode_t;

    typedef struct packed {
        kind_t kind;
        logic  more;
        logic  push_needed;
        logic  out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/ledit_if.sv -----
// Valid/ready channel interfaces for line editor items and results.
`timescale 1ns / 1ps

interface ledit_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] key;
    logic [7:0] read_index;

    modport source (output valid, output op, output key, output read_index, input ready);
    modport sink (input valid, input op, input key, input read_index, output ready);
endinterface

interface ledit_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_length;
    logic [7:0] cursor_position;
    logic       committed;
    logic [7:0] command_length;
    logic [7:0] read_data;

    modport source (output valid, output line_length, output cursor_position,
                    output committed, output command_length, output read_data,
                    input ready);
    modport sink (input valid, input line_length, input cursor_position,
                  input committed, input command_length, input read_data,
                  output ready);
endinterface

// ----- rtl/core/ledit_ctrl.sv -----
// Sequencing state machine of the line editor.
`timescale 1ns / 1ps
`include "line_editor_with_history_unit_macros.svh"

module ledit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output ledit_pkg::dp_cmd_t cmd,
    input  ledit_pkg::dp_stat_t stat
);
    import ledit_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_INS_RD   = 15'b000000000000100,
        S_INS_WR   = 15'b000000000001000,
        S_REM_RD   = 15'b000000000010000,
        S_REM_WR   = 15'b000000000100000,
        S_WORD_RD  = 15'b000000001000000,
        S_WORD_CHK = 15'b000000010000000,
        S_ENT_RD   = 15'b000000100000000,
        S_ENT_WR   = 15'b000001000000000,
        S_PSH_RD   = 15'b000010000000000,
        S_PSH_WR   = 15'b000100000000000,
        S_LD_RD    = 15'b001000000000000,
        S_LD_WR    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = DC_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = DC_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.kind)
                    KIND_SIMPLE:
                    begin
                        cmd        = DC_SIMPLE;
                        state_next = S_DONE;
                    end
                    KIND_INSERT:
                    begin
                        cmd        = DC_INS_START;
                        state_next = S_INS_RD;
                    end
                    KIND_BKSP:
                    begin
                        cmd        = DC_BS_START;
                        state_next = S_REM_RD;
                    end
                    KIND_DEL:
                    begin
                        cmd        = DC_DEL_START;
                        state_next = S_REM_RD;
                    end
                    KIND_WORD:
                    begin
                        cmd        = DC_WORD_START;
                        state_next = S_WORD_RD;
                    end
                    KIND_ENTER:
                    begin
                        cmd        = DC_ENT_START;
                        state_next = S_ENT_RD;
                    end
                    KIND_LOAD:
                    begin
                        cmd        = DC_LD_START;
                        state_next = S_LD_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (stat.more)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd        = DC_INS_PUT;
                    state_next = S_DONE;
                end
            end
            S_INS_WR:
            begin
                cmd        = DC_INS_STEP;
                state_next = S_INS_RD;
            end
            S_REM_RD:
            begin
                if (stat.more)
                begin
                    state_next = S_REM_WR;
                end
                else
                begin
                    cmd        = DC_REM_END;
                    state_next = S_DONE;
                end
            end
            S_REM_WR:
            begin
                cmd        = DC_REM_STEP;
                state_next = S_REM_RD;
            end
            S_WORD_RD:
            begin
                state_next = S_WORD_CHK;
            end
            S_WORD_CHK:
            begin
                if (stat.more)
                begin
                    cmd        = DC_WORD_STEP;
                    state_next = S_WORD_RD;
                end
                else
                begin
                    cmd        = DC_WORD_END;
                    state_next = S_REM_RD;
                end
            end
            S_ENT_RD:
            begin
                if (stat.more)
                begin
                    state_next = S_ENT_WR;
                end
                else
                begin
                    cmd        = DC_ENT_END;
                    state_next = stat.push_needed ? S_PSH_RD : S_DONE;
                end
            end
            S_ENT_WR:
            begin
                cmd        = DC_ENT_STEP;
                state_next = S_ENT_RD;
            end
            S_PSH_RD:
            begin
                if (stat.more)
                begin
                    state_next = S_PSH_WR;
                end
                else
                begin
                    cmd        = DC_PSH_END;
                    state_next = S_DONE;
                end
            end
            S_PSH_WR:
            begin
                cmd        = DC_PSH_STEP;
                state_next = S_PSH_RD;
            end
            S_LD_RD:
            begin
                if (stat.more)
                begin
                    state_next = S_LD_WR;
                end
                else
                begin
                    cmd        = DC_LD_END;
                    state_next = S_DONE;
                end
            end
            S_LD_WR:
            begin
                cmd        = DC_LD_STEP;
                state_next = S_LD_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd        = DC_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LEDIT_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd == DC_OUT_LOAD, stat.out_free)
    `LEDIT_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_reg == S_DECODE)
    `LEDIT_ASSERT_NEXT(a_done_idle, clk, rst_n, (state_reg == S_DONE) && stat.out_free, state_reg == S_IDLE)

endmodule

// ----- rtl/core/ledit_dp.sv -----
// Datapath of the line editor: line, command and history stores with their registers.
`timescale 1ns / 1ps
`include "line_editor_with_history_unit_macros.svh"

module ledit_dp #(
    parameter int LINE_BYTES    = 256,
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ledit_pkg::dp_cmd_t  cmd,
    output ledit_pkg::dp_stat_t stat,
    input  logic [2:0]          in_op,
    input  logic [7:0]          in_key,
    input  logic [7:0]          in_read_index,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          line_length,
    output logic [7:0]          cursor_position,
    output logic                committed,
    output logic [7:0]          command_length,
    output logic [7:0]          read_data
);
    import ledit_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam int SW = $clog2(HISTORY_DEPTH);
    localparam int XW = (LW > 8) ? LW : 8;
    localparam int HIST_WORDS = HISTORY_DEPTH * (2 ** LW);
    localparam logic [LW-1:0] LEN_MAX   = LW'(LINE_BYTES - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);

    op_t           op_reg, op_next;
    logic [7:0]    key_reg, key_next;
    logic [7:0]    idx_reg, idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] cmdlen_reg, cmdlen_next;
    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] bs_reg, bs_next;
    logic          phase_reg, phase_next;
    logic          eq_reg, eq_next;
    logic          enter_reg, enter_next;
    mode_t         mode_reg, mode_next;
    logic          out_valid_reg, out_valid_next;
    logic          hl_we;
    logic [LW-1:0] hl_reg [HISTORY_DEPTH];

    logic [7:0] edit_mem [LINE_BYTES];
    logic [7:0] cmd_mem [LINE_BYTES];
    logic [7:0] hist_mem [HIST_WORDS];
    logic [7:0] erd_reg;
    logic [7:0] crd_reg;
    logic [7:0] hrd_reg;

    logic [7:0] out_len_reg;
    logic [7:0] out_cur_reg;
    logic       out_com_reg;
    logic [7:0] out_cmdlen_reg;
    logic [7:0] out_data_reg;

    logic [SW-1:0]    prev_ws, ws_inc, older_slot, newer_slot, hl_addr, ld_slot;
    logic [LW-1:0]    hl_rd;
    logic             is_print, space, more, push_needed;
    logic [LW:0]      rem_sum;
    logic [LW-1:0]    word_start;
    logic [LW-1:0]    e_raddr, e_waddr;
    logic [7:0]       e_wdata;
    logic             e_we, c_we, h_we;
    logic [LW-1:0]    c_raddr;
    logic [SW+LW-1:0] h_raddr, h_waddr;
    kind_t            kind;
    logic [XW-1:0]    len_x, cur_x, cmdlen_x, idx_x;
    logic [7:0]       rd_val;

    assign prev_ws    = (ws_reg == '0) ? SLOT_LAST : ws_reg - 1'b1;
    assign ws_inc     = (ws_reg == SLOT_LAST) ? '0 : ws_reg + 1'b1;
    assign older_slot = (bs_reg == '0) ? SLOT_LAST : bs_reg - 1'b1;
    assign newer_slot = (bs_reg == SLOT_LAST) ? '0 : bs_reg + 1'b1;
    assign ld_slot    = (op_reg == OP_OLDER) ? older_slot : newer_slot;
    assign hl_addr    = (op_reg == OP_OLDER) ? older_slot
                      : (op_reg == OP_NEWER) ? newer_slot : prev_ws;
    assign hl_rd      = hl_reg[hl_addr];

    assign is_print    = (key_reg >= KEY_PRINT_LO) && (key_reg <= KEY_PRINT_HI);
    assign space       = (erd_reg == KEY_SPACE);
    assign rem_sum     = {1'b0, ptr_reg} + {1'b0, cnt_reg};
    assign word_start  = space ? ptr_reg + 1'b1 : ptr_reg;
    assign push_needed = (len_reg != '0) && !((hl_rd == len_reg) && eq_reg);

    always_comb
    begin
        kind = KIND_SIMPLE;
        case (op_reg)
            OP_KEY:
            begin
                if ((key_reg == KEY_LF) || (key_reg == KEY_CR))
                begin
                    kind = KIND_ENTER;
                end
                else if ((key_reg == KEY_BACKSPACE) || (key_reg == KEY_DELETE))
                begin
                    kind = (cur_reg != '0) ? KIND_BKSP : KIND_SIMPLE;
                end
                else if (key_reg == KEY_CTRL_D)
                begin
                    kind = (cur_reg < len_reg) ? KIND_DEL : KIND_SIMPLE;
                end
                else if (key_reg == KEY_CTRL_W)
                begin
                    kind = (cur_reg != '0) ? KIND_WORD : KIND_SIMPLE;
                end
                else if (is_print && (len_reg < LEN_MAX))
                begin
                    kind = KIND_INSERT;
                end
            end
            OP_OLDER:
            begin
                kind = (hl_rd != '0) ? KIND_LOAD : KIND_SIMPLE;
            end
            OP_NEWER:
            begin
                kind = (newer_slot != ws_reg) ? KIND_LOAD : KIND_SIMPLE;
            end
            OP_READ:
            begin
                kind = KIND_READ;
            end
            default:
            begin
                kind = KIND_SIMPLE;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_INS:   more = (ptr_reg > cur_reg);
            MODE_REM:   more = (rem_sum < {1'b0, len_reg});
            MODE_WORD:  more = (ptr_reg != '0) && (!phase_reg || !space);
            MODE_ENTER: more = (ptr_reg < len_reg);
            MODE_PUSH:  more = (ptr_reg < len_reg);
            MODE_LOAD:  more = (ptr_reg < n_reg);
            default:    more = 1'b0;
        endcase
    end

    assign stat.kind        = kind;
    assign stat.more        = more;
    assign stat.push_needed = push_needed;
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Store addressing.
    always_comb
    begin
        case (mode_reg)
            MODE_INS: e_raddr = ptr_reg - 1'b1;
            MODE_REM: e_raddr = rem_sum[LW-1:0];
            default:  e_raddr = ptr_reg;
        endcase
    end

    assign c_raddr = LW'(idx_reg);
    assign h_raddr = {((mode_reg == MODE_ENTER) ? prev_ws : bs_reg), ptr_reg};
    assign h_waddr = {ws_reg, ptr_reg};
    assign c_we    = (cmd == DC_ENT_STEP);
    assign h_we    = (cmd == DC_PSH_STEP);

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = ptr_reg;
        e_wdata = erd_reg;
        case (cmd)
            DC_INS_STEP:
            begin
                e_we = 1'b1;
            end
            DC_INS_PUT:
            begin
                e_we    = 1'b1;
                e_waddr = cur_reg;
                e_wdata = key_reg;
            end
            DC_REM_STEP:
            begin
                e_we = 1'b1;
            end
            DC_LD_STEP:
            begin
                e_we    = 1'b1;
                e_wdata = hrd_reg;
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edit_mem[e_waddr] <= e_wdata;
        end
        erd_reg <= edit_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cmd_mem[ptr_reg] <= erd_reg;
        end
        crd_reg <= cmd_mem[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hist_mem[h_waddr] <= erd_reg;
        end
        hrd_reg <= hist_mem[h_raddr];
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        cmdlen_next    = cmdlen_reg;
        ws_next        = ws_reg;
        bs_next        = bs_reg;
        phase_next     = phase_reg;
        eq_next        = eq_reg;
        enter_next     = enter_reg;
        mode_next      = mode_reg;
        hl_we          = 1'b0;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        case (cmd)
            DC_CAPTURE:
            begin
                op_next    = op_t'(in_op);
                key_next   = in_key;
                idx_next   = in_read_index;
                enter_next = 1'b0;
            end
            DC_SIMPLE:
            begin
                case (op_reg)
                    OP_KEY:
                    begin
                        case (key_reg)
                            KEY_CTRL_A: cur_next = '0;
                            KEY_CTRL_E: cur_next = len_reg;
                            KEY_CTRL_K: len_next = cur_reg;
                            KEY_CTRL_C, KEY_CTRL_U:
                            begin
                                len_next = '0;
                                cur_next = '0;
                            end
                            default:
                            begin
                                cur_next = cur_reg;
                            end
                        endcase
                    end
                    OP_LEFT:
                    begin
                        if (cur_reg != '0)
                        begin
                            cur_next = cur_reg - 1'b1;
                        end
                    end
                    OP_RIGHT:
                    begin
                        if (cur_reg < len_reg)
                        begin
                            cur_next = cur_reg + 1'b1;
                        end
                    end
                    OP_HOME: cur_next = '0;
                    OP_END:  cur_next = len_reg;
                    OP_NEWER:
                    begin
                        len_next = '0;
                        cur_next = '0;
                        bs_next  = ws_reg;
                    end
                    default:
                    begin
                        cur_next = cur_reg;
                    end
                endcase
            end
            DC_INS_START:
            begin
                mode_next = MODE_INS;
                ptr_next  = len_reg;
            end
            DC_INS_STEP:
            begin
                ptr_next = ptr_reg - 1'b1;
            end
            DC_INS_PUT:
            begin
                cur_next = cur_reg + 1'b1;
                len_next = len_reg + 1'b1;
            end
            DC_BS_START:
            begin
                mode_next = MODE_REM;
                cur_next  = cur_reg - 1'b1;
                ptr_next  = cur_reg - 1'b1;
                cnt_next  = LW'(1);
            end
            DC_DEL_START:
            begin
                mode_next = MODE_REM;
                ptr_next  = cur_reg;
                cnt_next  = LW'(1);
            end
            DC_REM_STEP:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            DC_REM_END:
            begin
                len_next = len_reg - cnt_reg;
            end
            DC_WORD_START:
            begin
                mode_next  = MODE_WORD;
                ptr_next   = cur_reg - 1'b1;
                phase_next = 1'b0;
            end
            DC_WORD_STEP:
            begin
                ptr_next   = ptr_reg - 1'b1;
                phase_next = phase_reg | !space;
            end
            DC_WORD_END:
            begin
                mode_next = MODE_REM;
                ptr_next  = word_start;
                cnt_next  = cur_reg - word_start;
                cur_next  = word_start;
            end
            DC_ENT_START:
            begin
                mode_next  = MODE_ENTER;
                ptr_next   = '0;
                eq_next    = 1'b1;
                enter_next = 1'b1;
            end
            DC_ENT_STEP:
            begin
                eq_next  = eq_reg && (erd_reg == hrd_reg);
                ptr_next = ptr_reg + 1'b1;
            end
            DC_ENT_END:
            begin
                cmdlen_next = len_reg;
                mode_next   = MODE_PUSH;
                ptr_next    = '0;
                if (!push_needed)
                begin
                    len_next = '0;
                    cur_next = '0;
                    if (len_reg != '0)
                    begin
                        bs_next = ws_reg;
                    end
                end
            end
            DC_PSH_STEP:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            DC_PSH_END:
            begin
                hl_we    = 1'b1;
                ws_next  = ws_inc;
                bs_next  = ws_inc;
                len_next = '0;
                cur_next = '0;
            end
            DC_LD_START:
            begin
                mode_next = MODE_LOAD;
                bs_next   = ld_slot;
                n_next    = hl_rd;
                ptr_next  = '0;
            end
            DC_LD_STEP:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            DC_LD_END:
            begin
                len_next = n_reg;
                cur_next = n_reg;
            end
            DC_OUT_LOAD:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
                hl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_KEY;
            key_reg       <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            cur_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            cmdlen_reg    <= '0;
            ws_reg        <= '0;
            bs_reg        <= '0;
            phase_reg     <= 1'b0;
            eq_reg        <= 1'b0;
            enter_reg     <= 1'b0;
            mode_reg      <= MODE_INS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg        <= op_next;
            key_reg       <= key_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            cmdlen_reg    <= cmdlen_next;
            ws_reg        <= ws_next;
            bs_reg        <= bs_next;
            phase_reg     <= phase_next;
            eq_reg        <= eq_next;
            enter_reg     <= enter_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hl_reg[i] <= '0;
            end
        end
        else if (hl_we)
        begin
            hl_reg[ws_reg] <= len_reg;
        end
    end

    // Result register; lengths wider than a byte are reported modulo 256.
    assign len_x    = XW'(len_reg);
    assign cur_x    = XW'(cur_reg);
    assign cmdlen_x = XW'(cmdlen_reg);
    assign idx_x    = XW'(idx_reg);
    assign rd_val   = ((op_reg == OP_READ) && (idx_x < cmdlen_x)) ? crd_reg : 8'd0;

    always_ff @(posedge clk)
    begin
        if (cmd == DC_OUT_LOAD)
        begin
            out_len_reg    <= len_x[7:0];
            out_cur_reg    <= cur_x[7:0];
            out_com_reg    <= enter_reg;
            out_cmdlen_reg <= cmdlen_x[7:0];
            out_data_reg   <= rd_val;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_length     = out_len_reg;
    assign cursor_position = out_cur_reg;
    assign committed       = out_com_reg;
    assign command_length  = out_cmdlen_reg;
    assign read_data       = out_data_reg;

    `LEDIT_ASSERT_NOW(a_cursor_in_line, clk, rst_n, 1'b1, cur_reg <= len_reg)
    `LEDIT_ASSERT_NOW(a_length_limit, clk, rst_n, 1'b1, len_reg <= LEN_MAX)
    `LEDIT_ASSERT_NOW(a_slots_in_ring, clk, rst_n, 1'b1, (ws_reg <= SLOT_LAST) && (bs_reg <= SLOT_LAST))

endmodule

// ----- rtl/core/line_editor_with_history_unit.sv -----
// Top level of the line editor with history ring.
// A new item is accepted only in the idle state, that is after the result of the last one has been loaded.
// Insert and delete shift the line byte by byte through read and write states; Ctrl+W first scans back.
// Enter copies the line byte by byte to commit it, then again to store a new history entry when one is needed.
// History browsing copies the entry byte by byte; a result held at the output stalls the input.
// Reset is asynchronous and active low; the history ring is empty after reset, no clearing pass.
`timescale 1ns / 1ps

module line_editor_with_history_unit #(
    parameter int LINE_BYTES    = 256,
    parameter int HISTORY_DEPTH = 10
) (
    input logic         clk,
    input logic         rst_n,
    ledit_in_if.sink    in_ch,
    ledit_out_if.source out_ch
);
    import ledit_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ledit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ledit_dp #(
        .LINE_BYTES    (LINE_BYTES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (in_ch.op),
        .in_key          (in_ch.key),
        .in_read_index   (in_ch.read_index),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .line_length     (out_ch.line_length),
        .cursor_position (out_ch.cursor_position),
        .committed       (out_ch.committed),
        .command_length  (out_ch.command_length),
        .read_data       (out_ch.read_data)
    );

endmodule

// ----- dv/tb_line_editor_with_history_unit.sv -----
// Self-checking testbench for the line editor with history ring, driven through valid/ready channels.
`timescale 1ns / 1ps

module tb_line_editor_with_history_unit;
    import ledit_pkg::*;

    localparam int LINE_MAX      = 256;
    localparam int RING_DEPTH    = 10;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 160;
    localparam int FILL_AT       = 60;
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [7:0] line_length;
        logic [7:0] cursor_position;
        logic       committed;
        logic [7:0] command_length;
        logic [7:0] read_data;
    } editor_result_t;

    typedef struct {
        op_t            op;
        logic [7:0]     key;
        logic [7:0]     read_index;
        logic           fixed;
        editor_result_t want;
    } edit_row_t;

    typedef struct {
        editor_result_t predicted;
        logic           fixed;
        editor_result_t typed;
    } pending_result_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   cycle_count;
    int   accepted_count;
    logic receiver_hold;
    logic calm_phase;
    logic cur_fixed;
    editor_result_t cur_want;

    logic [7:0] line_buf [LINE_MAX];
    int         line_len;
    int         line_cur;
    logic [7:0] cmd_buf [LINE_MAX];
    int         cmd_len;
    logic [7:0] ring_text [RING_DEPTH][LINE_MAX];
    int         ring_len [RING_DEPTH];
    int         ring_write;
    int         ring_browse;

    pending_result_t pending_results[$];
    edit_row_t       directed_rows[$];

    ledit_in_if  in_ch();
    ledit_out_if out_ch();

    line_editor_with_history_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
        error_count++;
    endtask

    function automatic void cut_bytes(input int start, input int count);
        for (int i = start; i + count < line_len; i++)
        begin
            line_buf[i] = line_buf[i + count];
        end
        line_len -= count;
    endfunction

    function automatic void load_slot(input int slot);
        for (int i = 0; i < ring_len[slot]; i++)
        begin
            line_buf[i] = ring_text[slot][i];
        end
        line_len = ring_len[slot];
        line_cur = ring_len[slot];
    endfunction

    function automatic void commit_line();
        int  prev;
        bit  same;
        for (int i = 0; i < line_len; i++)
        begin
            cmd_buf[i] = line_buf[i];
        end
        cmd_len = line_len;
        line_len = 0;
        line_cur = 0;
        if (cmd_len == 0)
        begin
            return;
        end
        prev = (ring_write + RING_DEPTH - 1) % RING_DEPTH;
        same = (ring_len[prev] == cmd_len);
        for (int i = 0; i < cmd_len && same; i++)
        begin
            if (ring_text[prev][i] != cmd_buf[i])
            begin
                same = 0;
            end
        end
        if (!same)
        begin
            for (int i = 0; i < cmd_len; i++)
            begin
                ring_text[ring_write][i] = cmd_buf[i];
            end
            ring_len[ring_write] = cmd_len;
            ring_write = (ring_write + 1) % RING_DEPTH;
        end
        ring_browse = ring_write;
    endfunction

    function automatic editor_result_t edit_step(input op_t op, input logic [7:0] key,
                                                 input logic [7:0] read_index);
        editor_result_t res;
        int slot;
        int start;
        res = '{default: '0};
        case (op)
            OP_KEY:
            begin
                if (key == KEY_LF || key == KEY_CR)
                begin
                    commit_line();
                    res.committed = 1'b1;
                end
                else if (key == KEY_BACKSPACE || key == KEY_DELETE)
                begin
                    if (line_cur > 0)
                    begin
                        line_cur--;
                        cut_bytes(line_cur, 1);
                    end
                end
                else if (key == KEY_CTRL_D)
                begin
                    if (line_cur < line_len)
                    begin
                        cut_bytes(line_cur, 1);
                    end
                end
                else if (key == KEY_CTRL_A)
                begin
                    line_cur = 0;
                end
                else if (key == KEY_CTRL_E)
                begin
                    line_cur = line_len;
                end
                else if (key == KEY_CTRL_K)
                begin
                    line_len = line_cur;
                end
                else if (key == KEY_CTRL_C || key == KEY_CTRL_U)
                begin
                    line_len = 0;
                    line_cur = 0;
                end
                else if (key == KEY_CTRL_W)
                begin
                    if (line_cur > 0)
                    begin
                        start = line_cur - 1;
                        while (start > 0 && line_buf[start] == KEY_SPACE)
                        begin
                            start--;
                        end
                        while (start > 0 && line_buf[start] != KEY_SPACE)
                        begin
                            start--;
                        end
                        if (line_buf[start] == KEY_SPACE)
                        begin
                            start++;
                        end
                        cut_bytes(start, line_cur - start);
                        line_cur = start;
                    end
                end
                else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI && line_len < LINE_MAX - 1)
                begin
                    for (int i = line_len; i > line_cur; i--)
                    begin
                        line_buf[i] = line_buf[i - 1];
                    end
                    line_buf[line_cur] = key;
                    line_cur++;
                    line_len++;
                end
            end
            OP_LEFT:
            begin
                if (line_cur > 0)
                begin
                    line_cur--;
                end
            end
            OP_RIGHT:
            begin
                if (line_cur < line_len)
                begin
                    line_cur++;
                end
            end
            OP_HOME:
            begin
                line_cur = 0;
            end
            OP_END:
            begin
                line_cur = line_len;
            end
            OP_OLDER:
            begin
                slot = (ring_browse + RING_DEPTH - 1) % RING_DEPTH;
                if (ring_len[slot] > 0)
                begin
                    ring_browse = slot;
                    load_slot(slot);
                end
            end
            OP_NEWER:
            begin
                slot = (ring_browse + 1) % RING_DEPTH;
                if (slot != ring_write)
                begin
                    ring_browse = slot;
                    load_slot(slot);
                end
                else
                begin
                    line_len = 0;
                    line_cur = 0;
                    ring_browse = ring_write;
                end
            end
            default:
            begin
                if (read_index < cmd_len)
                begin
                    res.read_data = cmd_buf[read_index];
                end
            end
        endcase
        res.line_length = line_len[7:0];
        res.cursor_position = line_cur[7:0];
        res.command_length = cmd_len[7:0];
        return res;
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] key, input logic [7:0] read_index,
                             input logic fixed, input editor_result_t want);
        int gap;
        gap = 0;
        if (!calm_phase && !receiver_hold)
        begin
            gap = ($urandom_range(0, 9) < 6) ? 0 :
                  ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.key        <= key;
        in_ch.read_index <= read_index;
        cur_fixed        <= fixed;
        cur_want         <= want;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic add_row(input op_t op, input logic [7:0] key, input logic [7:0] read_index,
                           input int fixed, input int len, input int cur, input int done,
                           input int clen, input int data);
        edit_row_t row;
        row.op = op;
        row.key = key;
        row.read_index = read_index;
        row.fixed = (fixed != 0);
        row.want.line_length = 8'(len);
        row.want.cursor_position = 8'(cur);
        row.want.committed = (done != 0);
        row.want.command_length = 8'(clen);
        row.want.read_data = 8'(data);
        directed_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        pending_result_t entry;
        pending_result_t head;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                entry.predicted = edit_step(op_t'(in_ch.op), in_ch.key, in_ch.read_index);
                entry.fixed = cur_fixed;
                entry.typed = cur_want;
                pending_results.push_back(entry);
                accepted_count <= accepted_count + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    head = pending_results.pop_front();
                    if (head.fixed && head.typed != head.predicted)
                    begin
                        report_mismatch("directed row vs predictor", 1, 0);
                    end
                    if (out_ch.line_length != head.predicted.line_length)
                        report_mismatch("line_length", int'(out_ch.line_length),
                                        int'(head.predicted.line_length));
                    if (out_ch.cursor_position != head.predicted.cursor_position)
                        report_mismatch("cursor_position", int'(out_ch.cursor_position),
                                        int'(head.predicted.cursor_position));
                    if (out_ch.committed != head.predicted.committed)
                        report_mismatch("committed", int'(out_ch.committed),
                                        int'(head.predicted.committed));
                    if (out_ch.command_length != head.predicted.command_length)
                        report_mismatch("command_length", int'(out_ch.command_length),
                                        int'(head.predicted.command_length));
                    if (out_ch.read_data != head.predicted.read_data)
                        report_mismatch("read_data", int'(out_ch.read_data),
                                        int'(head.predicted.read_data));
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_hold)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (calm_phase)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(20, 60);
            end
        end
    end

    initial
    begin
        receiver_hold = 1'b0;
        wait (accepted_count >= HOLD_AT);
        @(negedge clk);
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk);
        receiver_hold = 1'b0;
    end

    initial
    begin
        editor_result_t none;
        int r;
        int idle;
        op_t op;
        logic [7:0] key;
        logic [7:0] idx;
        logic [7:0] edit_keys [12];

        edit_keys = '{KEY_BACKSPACE, KEY_DELETE, KEY_CTRL_D, KEY_CTRL_A, KEY_CTRL_E,
                      KEY_CTRL_K, KEY_CTRL_U, KEY_CTRL_C, KEY_CTRL_W, KEY_CTRL_W,
                      8'd12, 8'd27};
        none = '{default: '0};
        error_count = 0;
        cycle_count = 0;
        accepted_count = 0;
        calm_phase = 1'b0;
        cur_fixed = 1'b0;
        cur_want = none;
        in_ch.valid = 1'b0;
        in_ch.op = OP_KEY;
        in_ch.key = '0;
        in_ch.read_index = '0;
        line_len = 0;
        line_cur = 0;
        cmd_len = 0;
        ring_write = 0;
        ring_browse = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_len[i] = 0;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(OP_READ,  8'd0,          8'd0,   1, 0, 0, 0, 0, 0);
        add_row(OP_LEFT,  8'd0,          8'd0,   1, 0, 0, 0, 0, 0);
        add_row(OP_OLDER, 8'd0,          8'd0,   1, 0, 0, 0, 0, 0);
        add_row(OP_NEWER, 8'd0,          8'd0,   1, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CR,        8'd0,   1, 0, 0, 1, 0, 0);
        add_row(OP_KEY,   KEY_PRINT_LO,  8'd0,   1, 1, 1, 0, 0, 0);
        add_row(OP_KEY,   KEY_PRINT_HI,  8'd0,   1, 2, 2, 0, 0, 0);
        add_row(OP_KEY,   8'd0,          8'd0,   1, 2, 2, 0, 0, 0);
        add_row(OP_KEY,   8'd255,        8'd0,   1, 2, 2, 0, 0, 0);
        add_row(OP_RIGHT, 8'd0,          8'd0,   1, 2, 2, 0, 0, 0);
        add_row(OP_KEY,   8'd97,         8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_LEFT,  8'd0,          8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_D,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_HOME,  8'd0,          8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_E,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_W,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_LF,        8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_READ,  8'd0,          8'd255, 1, 0, 0, 0, 1, 0);
        add_row(OP_READ,  8'd0,          8'd0,   1, 0, 0, 0, 1, 32);
        add_row(OP_OLDER, 8'd0,          8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_BACKSPACE, 8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_DELETE,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_END,   8'd0,          8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_A,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_K,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_NEWER, 8'd0,          8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_U,    8'd0,   0, 0, 0, 0, 0, 0);
        add_row(OP_KEY,   KEY_CTRL_C,    8'd0,   0, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].read_index,
                      directed_rows[i].fixed, directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm_phase = (n >= 100 && n < 130);
            if (n == FILL_AT)
            begin
                for (int f = 0; f < LINE_MAX + 4; f++)
                begin
                    send_item(OP_KEY, 8'($urandom_range(32, 126)), 8'd0, 1'b0, none);
                end
                send_item(OP_LEFT, 8'd0, 8'd0, 1'b0, none);
                send_item(OP_KEY, KEY_CTRL_W, 8'd0, 1'b0, none);
                send_item(OP_KEY, KEY_CR, 8'd0, 1'b0, none);
                send_item(OP_READ, 8'd0, 8'd254, 1'b0, none);
            end
            r = $urandom_range(0, 99);
            op = OP_KEY;
            key = 8'($urandom());
            idx = 8'($urandom());
            if (r < 42)
            begin
                key = ($urandom_range(0, 4) == 0) ? KEY_SPACE : 8'($urandom_range(32, 126));
            end
            else if (r < 55)
            begin
                key = edit_keys[$urandom_range(0, 11)];
            end
            else if (r < 60)
            begin
                key = 8'($urandom());
            end
            else if (r < 68)
            begin
                key = $urandom_range(0, 1) ? KEY_CR : KEY_LF;
            end
            else if (r < 75)
            begin
                op = OP_OLDER;
            end
            else if (r < 80)
            begin
                op = OP_NEWER;
            end
            else if (r < 90)
            begin
                op = op_t'($urandom_range(1, 4));
            end
            else
            begin
                op = OP_READ;
                if (cmd_len > 0 && $urandom_range(0, 1))
                begin
                    idx = 8'($urandom_range(0, cmd_len - 1));
                end
            end
            send_item(op, key, idx, 1'b0, none);
        end
        calm_phase = 1'b0;
        @(negedge clk);
        in_ch.valid <= 1'b0;

        idle = 0;
        while (pending_results.size() != 0 && idle < 200000)
        begin
            @(posedge clk);
            idle++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", error_count,
                     pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
